### design/spr_pkg.sv
// spr_pkg: shared types, constants and the crc step for the servo packet receive check
// no dependencies; compiled first

package spr_pkg;

   localparam int          MAX_LENGTH_DEFAULT = 1024;
   localparam logic [7:0]  DEVICE_ID_RESET    = 8'd1;
   localparam logic [15:0] CRC_POLY           = 16'h8005;
   localparam logic [7:0]  HDR_SYNC           = 8'hFF;
   localparam logic [7:0]  HDR_LAST           = 8'hFD;

   typedef enum logic [1:0] {
      STATUS_SUCCESS = 2'd0,
      STATUS_CORRUPT = 2'd1,
      STATUS_FOREIGN = 2'd2
   } status_type;

   typedef struct packed {
      logic       emit;
      status_type status;
      logic [7:0] instruction;
      logic [7:0] packet_id;
   } spr_result_type;

   // crc-16 msb first, one byte per call
   function automatic logic [15:0] spr_crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

### design/spr_if.sv
// spr_if: valid/ready channel interfaces for request items, response items and csr writes
// no dependencies

interface spr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface spr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] instruction;
   logic [7:0] packet_id;
   modport source (output valid, output status, output instruction, output packet_id,
                   input ready);
   modport sink   (input valid, input status, input instruction, input packet_id,
                   output ready);
endinterface

interface spr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] device_id;
   modport source (output valid, output device_id, input ready);
   modport sink   (input valid, input device_id, output ready);
endinterface

### design/spr_frame.sv
// spr_frame: packet framing state, header/id/length checks and running crc
// depends on spr_pkg

module spr_frame
   import spr_pkg::*;
#(
   parameter int MAX_LENGTH_FIELD = MAX_LENGTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     data_byte,
   input  logic           first_byte,
   input  logic [7:0]     device_id,
   output spr_result_type result
);

   localparam int          IDX_W     = $clog2(MAX_LENGTH_FIELD + 7);
   localparam logic [15:0] LEN_MAX   = 16'(MAX_LENGTH_FIELD);
   localparam logic [15:0] LEN_MIN   = 16'd3;
   localparam logic [IDX_W-1:0] IDX_RESERVED = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_ID       = IDX_W'(4);
   localparam logic [IDX_W-1:0] IDX_LEN_LO   = IDX_W'(5);
   localparam logic [IDX_W-1:0] IDX_LEN_HI   = IDX_W'(6);
   localparam logic [IDX_W-1:0] IDX_INSTR    = IDX_W'(7);
   localparam logic [IDX_W-1:0] IDX_HDR_LAST = IDX_W'(2);

   typedef enum logic {PH_IDLE, PH_RECV} phase_type;

   phase_type        phase_ff, phase_in, phase_eff;
   logic [IDX_W-1:0] idx_ff, idx_in, idx_eff;
   logic [15:0]      len_ff, len_in, len_eff;
   logic [15:0]      crc_ff, crc_in, crc_eff;
   logic [7:0]       crc_lo_ff, crc_lo_in, crc_lo_eff;
   logic [7:0]       ins_ff, ins_in, ins_eff;
   logic [7:0]       id_ff, id_in, id_eff;
   logic [15:0]      crc_step;
   logic [15:0]      len_full;
   logic [16:0]      len_end;
   logic [16:0]      idx_wide;

   always_comb begin
      // a first byte restarts reception from header byte 0
      phase_eff  = first_byte ? PH_RECV : phase_ff;
      idx_eff    = first_byte ? '0 : idx_ff;
      len_eff    = first_byte ? '0 : len_ff;
      crc_eff    = first_byte ? '0 : crc_ff;
      crc_lo_eff = first_byte ? '0 : crc_lo_ff;
      ins_eff    = first_byte ? '0 : ins_ff;
      id_eff     = first_byte ? '0 : id_ff;

      crc_step = spr_crc_byte(crc_eff, data_byte);
      len_full = {data_byte, len_eff[7:0]};
      len_end  = 17'(len_eff) + 17'd5;
      idx_wide = 17'(idx_eff);

      phase_in  = phase_eff;
      idx_in    = idx_eff;
      len_in    = len_eff;
      crc_in    = crc_eff;
      crc_lo_in = crc_lo_eff;
      ins_in    = ins_eff;
      id_in     = id_eff;

      result.emit        = 1'b0;
      result.status      = STATUS_SUCCESS;
      result.instruction = 8'd0;
      result.packet_id   = 8'd0;

      if (phase_eff == PH_RECV) begin
         idx_in = idx_eff + IDX_W'(1);
         if (idx_eff < IDX_RESERVED) begin
            crc_in = crc_step;
            if (data_byte != ((idx_eff == IDX_HDR_LAST) ? HDR_LAST : HDR_SYNC)) begin
               result.emit   = 1'b1;
               result.status = STATUS_CORRUPT;
               phase_in      = PH_IDLE;
            end
         end else if (idx_eff == IDX_RESERVED) begin
            crc_in = crc_step;
         end else if (idx_eff == IDX_ID) begin
            crc_in = crc_step;
            id_in  = data_byte;
            if (data_byte != device_id) begin
               result.emit      = 1'b1;
               result.status    = STATUS_FOREIGN;
               result.packet_id = data_byte;
               phase_in         = PH_IDLE;
            end
         end else if (idx_eff == IDX_LEN_LO) begin
            crc_in = crc_step;
            len_in = {8'd0, data_byte};
         end else if (idx_eff == IDX_LEN_HI) begin
            crc_in = crc_step;
            len_in = len_full;
            if (len_full < LEN_MIN || len_full > LEN_MAX) begin
               result.emit      = 1'b1;
               result.status    = STATUS_CORRUPT;
               result.packet_id = id_eff;
               phase_in         = PH_IDLE;
            end
         end else if (idx_wide < len_end) begin
            crc_in = crc_step;
            if (idx_eff == IDX_INSTR) begin
               ins_in = data_byte;
            end
         end else if (idx_wide == len_end) begin
            crc_lo_in = data_byte;
         end else begin
            // trailing crc high byte closes the packet
            result.emit        = 1'b1;
            result.status      = ({data_byte, crc_lo_eff} == crc_eff) ? STATUS_SUCCESS
                                                                      : STATUS_CORRUPT;
            result.instruction = ins_eff;
            result.packet_id   = id_eff;
            phase_in           = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      if (step) begin
         len_ff    <= len_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         ins_ff    <= ins_in;
         id_ff     <= id_in;
      end
   end

endmodule

### design/servo_packet_receive_check.sv
// servo_packet_receive_check: top level, input register, response register, device id csr
// depends on spr_pkg, spr_if interfaces and spr_frame
//
// Bytes of a servo-bus instruction packet arrive one item at a time on req_chan, with
// first_byte marking the start of a packet. The block checks the FF FF FD header, the id
// against device_id, the length field, and the crc-16 (poly 0x8005, init 0) over all but
// the two trailing crc bytes. One item goes out on rsp_chan per finished or rejected
// packet: status, instruction and packet_id. Bytes that cause no result produce nothing.
// Throughput is one byte per cycle while rsp_chan does not stall: each item is held in the
// input register, then the framing logic and crc byte step update the state and load the
// response register. A result is visible on rsp_chan right after the edge at which its byte
// leaves the input register. While a result waits on a stalled receiver, one more byte can
// be accepted into the input register; req_chan.ready drops only when both registers are
// full and rsp_chan.ready is low.
// csr_chan is always ready and writes device_id; write it only while no packet is in flight.
// Reset (synchronous) empties both registers, returns framing to idle and sets device_id to 1.

module servo_packet_receive_check
   import spr_pkg::*;
#(
   parameter int MAX_LENGTH_FIELD = MAX_LENGTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   spr_req_if.sink   req_chan,
   spr_rsp_if.source rsp_chan,
   spr_csr_if.sink   csr_chan
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_data_ff;
   logic           in_first_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff;
   logic [7:0]     rsp_instruction_ff;
   logic [7:0]     rsp_packet_id_ff;
   logic [7:0]     device_id_ff;
   logic           advance;
   logic           accept;
   spr_result_type result;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.instruction = rsp_instruction_ff;
   assign rsp_chan.packet_id   = rsp_packet_id_ff;

   spr_frame #(
      .MAX_LENGTH_FIELD(MAX_LENGTH_FIELD)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_data_ff),
      .first_byte (in_first_ff),
      .device_id  (device_id_ff),
      .result     (result)
   );

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      if (advance && result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         device_id_ff <= DEVICE_ID_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            device_id_ff <= csr_chan.device_id;
         end
      end
      if (accept) begin
         in_data_ff  <= req_chan.data_byte;
         in_first_ff <= req_chan.first_byte;
      end
      if (advance && result.emit) begin
         rsp_status_ff      <= result.status;
         rsp_instruction_ff <= result.instruction;
         rsp_packet_id_ff   <= result.packet_id;
      end
   end

endmodule

### design/spr_checker.sv
// spr_checker: port-level assertions for servo_packet_receive_check, with its bind
// depends on spr_pkg and the top level's channel interfaces

module spr_checker
   import spr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_instruction
);

   // a waiting result is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a new result needs a previously accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching accepted item");

   // an id mismatch never reports an instruction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FOREIGN |-> rsp_instruction == 8'd0)
      else $error("foreign packet carries an instruction");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind servo_packet_receive_check spr_checker u_spr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_instruction (rsp_chan.instruction)
);
